// ----- rtl/image_header_crc_checker_core_macros.svh -----
// Assertion macros used by the image header checker top level.
`ifndef IMAGE_HEADER_CRC_CHECKER_CORE_MACROS_SVH
`define IMAGE_HEADER_CRC_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IHCC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihcc check failed");

// Next-cycle implication, disabled during reset.
`define IHCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihcc check failed");

`endif

// ----- rtl/ihcc_pkg.sv -----
// Package: constants, types and the CRC step for the image header checker.
package ihcc_pkg;

   localparam int COUNT_BITS_DEF  = 29;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int TOTAL_BITS = 29;
   localparam int HDR_FIRST  = 8;
   localparam int HDR_LEN    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] CRC_POLY = 32'hedb88320;
   localparam logic [31:0] CRC_INIT = 32'hffffffff;

   localparam logic [31:0] WANT_VERSION_RST   = 32'd1;
   localparam logic [31:0] TABLE_LIMIT_RST    = 32'd4096;
   localparam logic [31:0] WANT_PAGE_SIZE_RST = 32'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_WANT_VERSION   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WANT_PAGE_SIZE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_SIGNATURE = 3'd2;
   localparam logic [2:0] ST_VERSION   = 3'd3;
   localparam logic [2:0] ST_TABLES    = 3'd4;
   localparam logic [2:0] ST_PAGE_SIZE = 3'd5;
   localparam logic [2:0] ST_CHECKSUM  = 3'd6;

   localparam logic [7:0] SIG_BYTES [8] = '{8'h51, 8'h46, 8'h45, 8'h4e, 8'h47, 8'h31,
                                            8'h00, 8'h00};

   // Everything the verdict stage needs about one finished image.
   typedef struct packed {
      logic                  short_img;
      logic                  sig_ok;
      logic [31:0]           version;
      logic [31:0]           tables;
      logic [63:0]           rows;
      logic [31:0]           page_len;
      logic [31:0]           stored_crc;
      logic [31:0]           computed_crc;
      logic [TOTAL_BITS-1:0] byte_total;
   } image_rec_type;

   // One reflected CRC-32 byte step, unrolled over eight bits.
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/ihcc_req_if.sv -----
// Interface: input byte channel of the image header checker.
interface ihcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output has_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                   output ready);
endinterface

// ----- rtl/ihcc_rsp_if.sv -----
// Interface: verdict channel of the image header checker.
interface ihcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] found_version;
   logic [31:0] found_tables;
   logic [63:0] found_rows;
   logic [31:0] found_page_size;
   logic [31:0] stored_crc;
   logic [31:0] computed_crc;
   logic [28:0] byte_total;

   modport source (output valid, output status, output found_version, output found_tables,
                   output found_rows, output found_page_size, output stored_crc,
                   output computed_crc, output byte_total, input ready);
   modport sink   (input valid, input status, input found_version, input found_tables,
                   input found_rows, input found_page_size, input stored_crc,
                   input computed_crc, input byte_total, output ready);
endinterface

// ----- rtl/ihcc_front.sv -----
// Front end: accepts byte words, parses the header, runs the CRC, emits image records.
module ihcc_front import ihcc_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ihcc_req_if.sink      req_bus,
   input  logic          q_full,
   output logic          q_push,
   output image_rec_type q_data
);

   logic [COUNT_BITS-1:0] cnt_ff, cnt_in, cnt_upd;
   logic                  sig_ff, sig_in, sig_upd;
   logic [31:0]           crc_ff, crc_in, crc_upd;
   logic [7:0]            hdr_ff  [HDR_FIRST:HDR_LEN-1];
   logic [7:0]            hdr_in  [HDR_FIRST:HDR_LEN-1];
   logic [7:0]            hdr_upd [HDR_FIRST:HDR_LEN-1];

   logic                  accept;
   logic                  take;
   logic                  in_hdr;
   logic [4:0]            idx;
   logic [TOTAL_BITS-1:0] total;

   assign req_bus.ready = ~q_full;
   assign accept        = req_bus.valid & req_bus.ready;
   assign take          = accept & req_bus.has_byte;
   assign in_hdr        = (cnt_ff[COUNT_BITS-1:5] == '0);
   assign idx           = cnt_ff[4:0];

   always_comb begin
      sig_upd = sig_ff;
      crc_upd = crc_ff;
      hdr_upd = hdr_ff;
      cnt_upd = cnt_ff;
      if (take) begin
         if (!in_hdr) begin
            crc_upd = crc_byte(crc_ff, req_bus.data_byte);
         end else if (idx < 5'(HDR_FIRST)) begin
            if (req_bus.data_byte != SIG_BYTES[idx[2:0]]) begin
               sig_upd = 1'b0;
            end
         end else begin
            hdr_upd[idx] = req_bus.data_byte;
         end
         if (cnt_ff != '1) begin
            cnt_upd = cnt_ff + 1'b1;
         end
      end
   end

   // Saturate the byte count to the reported width.
   generate
      if (COUNT_BITS > TOTAL_BITS) begin : g_sat
         assign total = (cnt_upd[COUNT_BITS-1:TOTAL_BITS] != '0) ? '1
                                                                  : cnt_upd[TOTAL_BITS-1:0];
      end else if (COUNT_BITS == TOTAL_BITS) begin : g_same
         assign total = cnt_upd;
      end else begin : g_ext
         assign total = {{(TOTAL_BITS-COUNT_BITS){1'b0}}, cnt_upd};
      end
   endgenerate

   always_comb begin
      q_data.short_img    = (cnt_upd[COUNT_BITS-1:5] == '0);
      q_data.sig_ok       = sig_upd;
      q_data.version      = {hdr_upd[11], hdr_upd[10], hdr_upd[9], hdr_upd[8]};
      q_data.tables       = {hdr_upd[15], hdr_upd[14], hdr_upd[13], hdr_upd[12]};
      q_data.rows         = {hdr_upd[23], hdr_upd[22], hdr_upd[21], hdr_upd[20],
                             hdr_upd[19], hdr_upd[18], hdr_upd[17], hdr_upd[16]};
      q_data.page_len     = {hdr_upd[27], hdr_upd[26], hdr_upd[25], hdr_upd[24]};
      q_data.stored_crc   = {hdr_upd[31], hdr_upd[30], hdr_upd[29], hdr_upd[28]};
      q_data.computed_crc = ~crc_upd;
      q_data.byte_total   = total;
   end

   assign q_push = accept & req_bus.last_byte;

   // Drop per-image state after the marked word.
   always_comb begin
      if (q_push) begin
         cnt_in = '0;
         sig_in = 1'b1;
         crc_in = CRC_INIT;
         for (int i = HDR_FIRST; i < HDR_LEN; i++) begin
            hdr_in[i] = 8'd0;
         end
      end else begin
         cnt_in = cnt_upd;
         sig_in = sig_upd;
         crc_in = crc_upd;
         hdr_in = hdr_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sig_ff <= 1'b1;
         crc_ff <= CRC_INIT;
         for (int i = HDR_FIRST; i < HDR_LEN; i++) begin
            hdr_ff[i] <= 8'd0;
         end
      end else begin
         cnt_ff <= cnt_in;
         sig_ff <= sig_in;
         crc_ff <= crc_in;
         hdr_ff <= hdr_in;
      end
   end

endmodule

// ----- rtl/ihcc_queue.sv -----
// Short queue of image records between the front end and the verdict stage.
module ihcc_queue import ihcc_pkg::*; #(
   parameter int WIDTH = $bits(image_rec_type),
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/ihcc_back.sv -----
// Verdict stage: holds the limit registers, grades records, drives the result register.
module ihcc_back import ihcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_empty,
   input  image_rec_type         q_data,
   output logic                  q_pop,
   ihcc_rsp_if.source            rsp_bus
);

   logic [31:0]   want_ver_ff, want_ver_in;
   logic [31:0]   tab_lim_ff, tab_lim_in;
   logic [31:0]   want_page_ff, want_page_in;
   logic          out_valid_ff, out_valid_in;
   logic [2:0]    status_ff, status_in;
   image_rec_type rec_ff;
   logic [2:0]    grade;

   always_comb begin
      want_ver_in  = want_ver_ff;
      tab_lim_in   = tab_lim_ff;
      want_page_in = want_page_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WANT_VERSION:   want_ver_in  = csr_wdata;
            CSR_TABLE_LIMIT:    tab_lim_in   = csr_wdata;
            CSR_WANT_PAGE_SIZE: want_page_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // First failing check wins.
   always_comb begin
      if (q_data.short_img) begin
         grade = ST_SHORT;
      end else if (!q_data.sig_ok) begin
         grade = ST_SIGNATURE;
      end else if (q_data.version != want_ver_ff) begin
         grade = ST_VERSION;
      end else if (q_data.tables > tab_lim_ff) begin
         grade = ST_TABLES;
      end else if (q_data.page_len != want_page_ff) begin
         grade = ST_PAGE_SIZE;
      end else if (q_data.stored_crc != q_data.computed_crc) begin
         grade = ST_CHECKSUM;
      end else begin
         grade = ST_OK;
      end
   end

   assign q_pop        = ~q_empty & (~out_valid_ff | rsp_bus.ready);
   assign out_valid_in = q_pop | (out_valid_ff & ~rsp_bus.ready);
   assign status_in    = q_pop ? grade : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         want_ver_ff  <= WANT_VERSION_RST;
         tab_lim_ff   <= TABLE_LIMIT_RST;
         want_page_ff <= WANT_PAGE_SIZE_RST;
         out_valid_ff <= 1'b0;
      end else begin
         want_ver_ff  <= want_ver_in;
         tab_lim_ff   <= tab_lim_in;
         want_page_ff <= want_page_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (q_pop) begin
         rec_ff <= q_data;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.status          = status_ff;
   assign rsp_bus.found_version   = rec_ff.version;
   assign rsp_bus.found_tables    = rec_ff.tables;
   assign rsp_bus.found_rows      = rec_ff.rows;
   assign rsp_bus.found_page_size = rec_ff.page_len;
   assign rsp_bus.stored_crc      = rec_ff.stored_crc;
   assign rsp_bus.computed_crc    = rec_ff.computed_crc;
   assign rsp_bus.byte_total      = rec_ff.byte_total;

endmodule

// ----- rtl/image_header_crc_checker_core.sv -----
// Top level of the image header checker: front end, record queue and verdict stage.
//
// The block takes a database image one byte word per cycle on req_bus, with last_byte
// marking the end of the image (a word with has_byte low only carries the mark, which
// lets an empty image through). Bytes 0..7 are matched against the signature, bytes
// 8..31 fill the little-endian header fields, and every byte from offset 32 on feeds a
// reflected CRC-32 whose one-byte step is fully unrolled, so the front end sustains one
// word per clock with no bubbles. Each marked word produces exactly one verdict on
// rsp_bus. Verdicts pass through a short record queue (QUEUE_DEPTH entries) and an
// output register, so the byte stream keeps flowing while a verdict waits for
// rsp_bus.ready; req_bus.ready drops only when the queue is full. The status reports
// the first failing check in the order: too short, signature, version, table count
// above table_limit, page size, checksum mismatch. The byte counter is COUNT_BITS wide
// and saturates; byte_total reports it clipped to 29 bits. The three limit registers
// are written on the csr_ port (index 0 want_version, 1 table_limit, 2 want_page_size,
// others ignored); the user must write them only while no image is in flight, which the
// block does not enforce; a write affects the next verdict that is graded.
module image_header_crc_checker_core import ihcc_pkg::*; #(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ihcc_req_if.sink              req_bus,
   ihcc_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "image_header_crc_checker_core_macros.svh"

   localparam int REC_W = $bits(image_rec_type);

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   image_rec_type q_in_data;
   image_rec_type q_out_data;

   // Parse bytes and hand one record per image to the queue.
   ihcc_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_in_data)
   );

   // Decouple parsing from the result handshake.
   ihcc_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Grade records against the limit registers and present the verdict.
   ihcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_empty   (q_empty),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .rsp_bus   (rsp_bus)
   );

   // Queue never overflows or underflows; a finished image always lands in the queue;
   // a new verdict appears only after a record was taken from the queue.
   `IHCC_ASSERT_NOW(a_no_push_full, clock, reset, q_push, !q_full)
   `IHCC_ASSERT_NOW(a_no_pop_empty, clock, reset, q_pop, !q_empty)
   `IHCC_ASSERT_NEXT(a_push_lands, clock, reset, q_push, !q_empty)
   `IHCC_ASSERT_NOW(a_rsp_from_pop, clock, reset, $rose(rsp_bus.valid), $past(q_pop))

endmodule

// ----- tb/image_header_crc_checker_core_tb.sv -----
// Testbench for the image header checker: builds byte-serial images and checks each verdict.
module image_header_crc_checker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ihcc_pkg::*;

   // Index past the end of the register list; the block must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Header layout, byte offsets of the little-endian fields.
   localparam int OFF_TABLES = 12;
   localparam int OFF_ROWS   = 16;
   localparam int OFF_PAGE   = 24;
   localparam int OFF_SUM    = 28;

   localparam int CNT_W       = COUNT_BITS_DEF;
   localparam int LATENCY_PAD = 8;      // cycles to let in-flight words settle
   localparam int MAX_SHOWN   = 10;     // mismatches reported in full
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off

   typedef enum int {
      IMG_GOOD, IMG_SHORT, IMG_BAD_SIG, IMG_BAD_VER, IMG_BAD_TABLES,
      IMG_BAD_PAGE, IMG_BAD_SUM, IMG_NOISE
   } image_kind_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [31:0]           version;
      logic [31:0]           tables;
      logic [63:0]           rows;
      logic [31:0]           page_len;
      logic [31:0]           stored_crc;
      logic [31:0]           computed_crc;
      logic [TOTAL_BITS-1:0] total;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ihcc_req_if req_bus ();
   ihcc_rsp_if rsp_bus ();

   image_header_crc_checker_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the limit registers.
   logic [31:0] cfg_version;
   logic [31:0] cfg_table_limit;
   logic [31:0] cfg_page_size;

   // Shadow copy of the per-image state.
   logic [CNT_W-1:0] img_count;
   logic             img_sig_ok;
   logic [31:0]      img_version;
   logic [31:0]      img_tables;
   logic [63:0]      img_rows;
   logic [31:0]      img_page;
   logic [31:0]      img_sum;
   logic [31:0]      img_crc;

   verdict_type pending_verdicts[$];

   int mismatches    = 0;
   int words_sent    = 0;
   int verdicts_seen = 0;
   bit idle_on       = 1'b1;
   int hold_request  = 0;

   // -------------------------------------------------------------------------
   // Clock and run limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous bound: far beyond the slowest legal run, gaps and stalls included.
   initial begin
      #(5_000_000);
      $display("tb: failure");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Reflected CRC-32, one byte fed LSB first, one bit per iteration.
   function automatic logic [31:0] crc_ref_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   task automatic clear_image_state();
      img_count   = '0;
      img_sig_ok  = 1'b1;
      img_version = '0;
      img_tables  = '0;
      img_rows    = '0;
      img_page    = '0;
      img_sum     = '0;
      img_crc     = CRC_INIT;
   endtask

   // Advance the shadow state by one accepted word; a marked word yields a verdict.
   task automatic predict_word(logic [7:0] d, logic has, logic last);
      verdict_type v;
      int       pos;
      logic [31:0] crc_final;
      if (has) begin
         pos = int'(img_count);
         if (pos < HDR_FIRST) begin
            if (d != SIG_BYTES[pos]) img_sig_ok = 1'b0;
         end else if (pos < OFF_TABLES) begin
            img_version |= 32'(d) << (8 * (pos - HDR_FIRST));
         end else if (pos < OFF_ROWS) begin
            img_tables |= 32'(d) << (8 * (pos - OFF_TABLES));
         end else if (pos < OFF_PAGE) begin
            img_rows |= 64'(d) << (8 * (pos - OFF_ROWS));
         end else if (pos < OFF_SUM) begin
            img_page |= 32'(d) << (8 * (pos - OFF_PAGE));
         end else if (pos < HDR_LEN) begin
            img_sum |= 32'(d) << (8 * (pos - OFF_SUM));
         end else begin
            img_crc = crc_ref_step(img_crc, d);
         end
         // Counter holds at all ones; the CRC keeps running regardless.
         if (img_count != '1) img_count = img_count + 1'b1;
      end
      if (last) begin
         crc_final = ~img_crc;
         // First failing check wins.
         if (img_count < HDR_LEN)                v.status = ST_SHORT;
         else if (!img_sig_ok)                   v.status = ST_SIGNATURE;
         else if (img_version != cfg_version)    v.status = ST_VERSION;
         else if (img_tables > cfg_table_limit)  v.status = ST_TABLES;
         else if (img_page != cfg_page_size)     v.status = ST_PAGE_SIZE;
         else if (img_sum != crc_final)          v.status = ST_CHECKSUM;
         else                                    v.status = ST_OK;
         v.version      = img_version;
         v.tables       = img_tables;
         v.rows         = img_rows;
         v.page_len     = img_page;
         v.stored_crc   = img_sum;
         v.computed_crc = crc_final;
         v.total        = TOTAL_BITS'(img_count);
         pending_verdicts.push_back(v);
         clear_image_state();
      end
   endtask

   // -------------------------------------------------------------------------
   // Verdict checker: compare every accepted verdict with the oldest prediction
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status       = rsp_bus.status;
         got.version      = rsp_bus.found_version;
         got.tables       = rsp_bus.found_tables;
         got.rows         = rsp_bus.found_rows;
         got.page_len     = rsp_bus.found_page_size;
         got.stored_crc   = rsp_bus.stored_crc;
         got.computed_crc = rsp_bus.computed_crc;
         got.total        = rsp_bus.byte_total;
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("%0t: verdict with none pending, status %0d", $realtime, got.status);
         end else begin
            want = pending_verdicts.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("%0t: exp st=%0d ver=%h tab=%h rows=%h page=%h sum=%h crc=%h n=%0d",
                           $realtime, want.status, want.version, want.tables, want.rows,
                           want.page_len, want.stored_crc, want.computed_crc, want.total);
                  $display("%0t: got st=%0d ver=%h tab=%h rows=%h page=%h sum=%h crc=%h n=%0d",
                           $realtime, got.status, got.version, got.tables, got.rows,
                           got.page_len, got.stored_crc, got.computed_crc, got.total);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Verdict receiver: random stall bursts plus an optional long hold-off
   // -------------------------------------------------------------------------
   initial begin : drive_rsp_ready
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender helpers
   // -------------------------------------------------------------------------

   // Offer one word, hold it until accepted, then advance the predictor.
   // Entered and left at a falling edge; valid stays high for a following word.
   task automatic send_word(logic [7:0] d, logic has, logic last);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= d;
      req_bus.has_byte  <= has;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_word(d, has, last);
      if (has || last) words_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted verdict has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_verdicts.size() != 0);
   endtask

   // Write one register while the block is idle, then mirror it in the shadow copy.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      wait_drained();
      // Unmarked words may still be in the front end; let them settle.
      repeat (LATENCY_PAD) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_WANT_VERSION:   cfg_version     = val;
         CSR_TABLE_LIMIT:    cfg_table_limit = val;
         CSR_WANT_PAGE_SIZE: cfg_page_size   = val;
         default: ;
      endcase
   endtask

   task automatic write_limits(logic [31:0] ver, logic [31:0] tabs, logic [31:0] page);
      write_reg(CSR_WANT_VERSION, ver);
      write_reg(CSR_TABLE_LIMIT, tabs);
      write_reg(CSR_WANT_PAGE_SIZE, page);
   endtask

   function automatic logic [31:0] rand_nonzero();
      logic [31:0] x;
      do x = $urandom(); while (x == 0);
      return x;
   endfunction

   function automatic image_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 19);
      if (r < 9)        return IMG_GOOD;
      else if (r < 11)  return IMG_SHORT;
      else if (r == 11) return IMG_BAD_SIG;
      else if (r == 12) return IMG_BAD_VER;
      else if (r == 13) return IMG_BAD_TABLES;
      else if (r == 14) return IMG_BAD_PAGE;
      else if (r < 17)  return IMG_BAD_SUM;
      else              return IMG_NOISE;
   endfunction

   function automatic int pick_payload_len();
      if ($urandom_range(0, 7) == 0) return $urandom_range(40, 160);
      return $urandom_range(0, 12);
   endfunction

   // Build one image around the current limits, spoiled as the kind says, and stream it.
   task automatic send_image(image_kind_type kind, int pay_len);
      logic [7:0]  img[$];
      logic [31:0] ver, tabs, page, sum, crc;
      logic [63:0] rows, span;
      logic [7:0]  b;
      bit          sep_mark;
      int          cut;
      ver  = cfg_version;
      page = cfg_page_size;
      rows = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
         0: tabs = cfg_table_limit;
         1: tabs = '0;
         default: begin
            span = 64'(cfg_table_limit) + 64'd1;
            tabs = 32'({$urandom(), $urandom()} % span);
         end
      endcase
      // A table count above the limit cannot exist when the limit is all ones.
      if (kind == IMG_BAD_TABLES && cfg_table_limit == '1) kind = IMG_GOOD;
      if (kind == IMG_BAD_TABLES) begin
         span = 64'hffff_ffff - 64'(cfg_table_limit);
         tabs = 32'(64'(cfg_table_limit) + 64'd1 + ({$urandom(), $urandom()} % span));
      end
      if (kind == IMG_BAD_VER)  ver  = ver ^ rand_nonzero();
      if (kind == IMG_BAD_PAGE) page = page ^ rand_nonzero();

      for (int k = 0; k < HDR_FIRST; k++) img.push_back(SIG_BYTES[k]);
      if (kind == IMG_BAD_SIG) begin
         cut = $urandom_range(0, HDR_FIRST - 1);
         img[cut] = img[cut] ^ 8'($urandom_range(1, 255));
      end
      for (int k = 0; k < 4; k++) img.push_back(ver[8*k +: 8]);
      for (int k = 0; k < 4; k++) img.push_back(tabs[8*k +: 8]);
      for (int k = 0; k < 8; k++) img.push_back(rows[8*k +: 8]);
      for (int k = 0; k < 4; k++) img.push_back(page[8*k +: 8]);

      crc = CRC_INIT;
      for (int k = 0; k < pay_len; k++) crc = crc_ref_step(crc, 8'(k * 37 + 11));
      sum = ~crc;
      // Payload bytes are random, so the checksum is recomputed after drawing them.
      crc = CRC_INIT;
      for (int k = 0; k < pay_len; k++) begin
         b = 8'($urandom());
         crc = crc_ref_step(crc, b);
         img.push_back(b);
      end
      sum = ~crc;
      if (kind == IMG_BAD_SUM) sum = sum ^ rand_nonzero();
      for (int k = 0; k < 4; k++) img.insert(OFF_SUM + k, sum[8*k +: 8]);

      if (kind == IMG_SHORT) begin
         cut = $urandom_range(0, HDR_LEN - 1);
         while (img.size() > cut) void'(img.pop_back());
      end
      if (kind == IMG_NOISE) begin
         img.delete();
         repeat ($urandom_range(0, pay_len + 40)) img.push_back(8'($urandom()));
      end

      // Mark either the final byte or a separate byte-less word.
      sep_mark = (img.size() == 0) || ($urandom_range(0, 3) == 0);
      foreach (img[i]) begin
         if ($urandom_range(0, 15) == 0) send_word(8'($urandom()), 1'b0, 1'b0);
         send_word(img[i], 1'b1, !sep_mark && (i == img.size() - 1));
      end
      if (sep_mark) send_word(8'($urandom()), 1'b0, 1'b1);
   endtask

   // Random images until the word budget is spent.
   task automatic run_random_images(int n_words);
      int goal;
      goal = words_sent + n_words;
      while (words_sent < goal) begin
         send_image(pick_kind(), pick_payload_len());
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset limits: empty and short images, each verdict code, bare header, fillers.
   task automatic test_reset_limits();
      send_word(8'h00, 1'b0, 1'b1);           // empty image
      send_word(8'hff, 1'b0, 1'b0);           // filler word only, no verdict
      send_word(8'hff, 1'b1, 1'b1);           // one-byte image
      send_image(IMG_GOOD, 0);                // header only, checksum of nothing
      send_image(IMG_GOOD, 3);
      send_image(IMG_SHORT, 0);
      send_image(IMG_BAD_SIG, 1);
      send_image(IMG_BAD_VER, 1);
      send_image(IMG_BAD_TABLES, 1);
      send_image(IMG_BAD_PAGE, 1);
      send_image(IMG_BAD_SUM, 2);
      send_image(IMG_NOISE, 0);
   endtask

   // All-zero and all-ones limits, each image kind but noise against them.
   task automatic test_limit_extremes();
      write_limits(32'h0, 32'h0, 32'h0);
      for (int k = IMG_GOOD; k <= IMG_BAD_SUM; k++) send_image(image_kind_type'(k), 2);
      write_limits(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      for (int k = IMG_GOOD; k <= IMG_BAD_SUM; k++) send_image(image_kind_type'(k), 2);
   endtask

   // A write to the spare index must leave every limit alone.
   task automatic test_spare_index();
      write_limits(32'd1, 32'd4096, 32'd4096);
      write_reg(CSR_SPARE, $urandom());
      send_image(IMG_GOOD, 4);
      send_image(IMG_BAD_VER, 0);
      send_image(IMG_BAD_PAGE, 0);
   endtask

   // Hold the receiver off while images keep coming, so the queue fills and input stalls.
   task automatic test_backpressure();
      wait_drained();
      @(posedge clock);
      hold_request = HOLD_CYCLES;
      @(negedge clock);
      repeat (24) send_word(8'($urandom()), 1'b0, 1'b1);
      repeat (4) send_image(IMG_SHORT, 0);
      send_image(IMG_GOOD, 1);
      // Pause the sender until every verdict is back.
      wait_drained();
   endtask

   // Several random limit settings, random traffic under each.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         write_limits(($urandom_range(0, 1) == 0) ? 32'd1 : 32'($urandom()),
                      32'($urandom()),
                      ($urandom_range(0, 1) == 0) ? 32'd4096 : 32'($urandom()));
         run_random_images(140);
      end
   endtask

   // Closing stretch: no idling on either side.
   task automatic test_steady_stream();
      write_limits(32'd1, 32'($urandom_range(0, 8192)), 32'd4096);
      idle_on = 1'b0;
      run_random_images(130);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : run_tests
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.has_byte  = 1'b0;
      req_bus.last_byte = 1'b0;
      cfg_version       = WANT_VERSION_RST;
      cfg_table_limit   = TABLE_LIMIT_RST;
      cfg_page_size     = WANT_PAGE_SIZE_RST;
      clear_image_state();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_limits();
      test_limit_extremes();
      test_spare_index();
      test_backpressure();
      test_random_traffic();
      test_steady_stream();

      // Drain, then leave room for any stray verdict to show up.
      wait_drained();
      repeat (LATENCY_PAD * 4) @(negedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ihcc_pkg.sv
rtl/ihcc_req_if.sv
rtl/ihcc_rsp_if.sv
rtl/ihcc_front.sv
rtl/ihcc_queue.sv
rtl/ihcc_back.sv
rtl/image_header_crc_checker_core.sv
tb/image_header_crc_checker_core_tb.sv
